FILE: design/k_way_sorted_merge_assert.svh
// Assertion macros for the k-way sorted merge.
// Included by kwsm_dp, which checks its own logic; needs nothing else.
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KWSM_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kwsm assertion failed");

// Next-cycle implication, checked outside reset.
`define KWSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kwsm assertion failed");

`endif

FILE: design/kwsm_pkg.sv
// Shared types and constants for the k-way sorted merge.
// Used by the controller, the datapath and the top level; depends on nothing.
package kwsm_pkg;

  localparam int unsigned LANES_DEF      = 8;
  localparam int unsigned FIFO_DEPTH_DEF = 8;
  localparam int unsigned MAX_OUT        = 64;

  localparam int unsigned LANE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CMP_W    = 5;
  localparam int unsigned RESCNT_W = 7;

  localparam logic [CFG_W-1:0] LANES_USED_RST = 4'd8;

  typedef enum logic [1:0] {
    ST_DATA   = 2'd0,
    ST_FULL   = 2'd1,
    ST_CLOSED = 2'd2,
    ST_END    = 2'd3
  } kwsm_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_SCAN,
    S_TAIL,
    S_POP,
    S_MARK,
    S_LAST
  } kwsm_state_e;

  typedef struct packed {
    logic idle;
    logic accept;
    logic check;
    logic scan_start;
    logic scan_step;
    logic scan_tail;
    logic pop;
    logic clear;
    logic mark;
    logic last;
    logic set_done;
  } kwsm_cmd_t;

  typedef struct packed {
    logic blocked;
    logic any_cand;
    logic all_done;
    logic cap_hit;
    logic scan_last;
    logic pend_valid;
    logic out_free;
    logic emitted;
  } kwsm_stat_t;

endpackage

FILE: design/k_way_sorted_merge.sv
// K-way merge of ascending signed streams into one ascending stream.
// Input channel (in_valid_i / in_stall_o): one item per handshake, carrying a
//   lane index, a value, has_value_i and lane_end_i. Items go into per-lane
//   FIFOs of FIFO_DEPTH entries held in one shared RAM.
// Output channel (out_valid_o / out_stall_i): merged values, drop flags for
//   items sent to a full FIFO or a closed or unused lane, and an end marker
//   when a merge completes without data. run_last_o tags the last result an
//   item causes; merge_done_o tags the final result of a complete merge.
// Config channel (cfg_valid_i / cfg_ready_o): writes lanes_used; ready only
//   while the block is idle.
// Sequence: an item that yields no data passes accept, check, evaluate and
//   finish; an end marker adds a mark step, and each merged value adds a
//   head scan, which reads one lane's FIFO head from the RAM per cycle, a
//   tail step, a pop and a new evaluate. A new item is taken only after all
//   results of the previous one have reached the output register.
// Reset clears all lanes (open, empty) and sets lanes_used to 8.
// While the receiver stalls, the output register holds its result and one
//   further result waits in a pending stage; the sequencer then pauses.
module k_way_sorted_merge import kwsm_pkg::*; #(
  parameter int unsigned LANES      = LANES_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [LANE_W-1:0]         lane_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      has_value_i,
  input  logic                      lane_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [VALUE_W-1:0] merged_value_o,
  output logic [LANE_W-1:0]         source_lane_o,
  output logic [1:0]                status_o,
  output logic                      merge_done_o,
  output logic                      run_last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_W-1:0]          cfg_data_i
);

  kwsm_cmd_t  cmd;
  kwsm_stat_t stat;

  kwsm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kwsm_dp #(
    .LANES      (LANES),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .lane_i         (lane_i),
    .value_i        (value_i),
    .has_value_i    (has_value_i),
    .lane_end_i     (lane_end_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .merged_value_o (merged_value_o),
    .source_lane_o  (source_lane_o),
    .status_o       (status_o),
    .merge_done_o   (merge_done_o),
    .run_last_o     (run_last_o)
  );

  assign cfg_ready_o = cmd.idle;

endmodule

FILE: design/kwsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the per-lane FIFO entries; no dependencies.
module kwsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/kwsm_ctrl.sv
// Controller for the k-way sorted merge: sequences check, scan, pop and finish.
// Depends on kwsm_pkg for the state enum and the command/status structs.
module kwsm_ctrl import kwsm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  kwsm_stat_t stat_i,
  output kwsm_cmd_t  cmd_o
);

  kwsm_state_e state_q, state_d;
  logic        done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_d  = done_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        if (!stat_i.cap_hit && !stat_i.blocked && stat_i.any_cand) begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end else begin
          // no pop: rearm all lanes if merge complete, then close out the item
          cmd_o.clear = stat_i.all_done;
          done_d      = stat_i.all_done;
          state_d     = (stat_i.all_done && !stat_i.emitted) ? S_MARK : S_LAST;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.scan_tail = 1'b1;
        state_d         = S_POP;
      end
      S_POP: begin
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.pop = 1'b1;
          state_d   = S_EVAL;
        end
      end
      S_MARK: begin
        if (!stat_i.pend_valid || stat_i.out_free) begin
          cmd_o.mark = 1'b1;
          state_d    = S_LAST;
        end
      end
      S_LAST: begin
        if (!stat_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.last     = 1'b1;
          cmd_o.set_done = done_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = !cmd_o.idle;

endmodule

FILE: design/kwsm_dp.sv
// Datapath for the k-way sorted merge: lane FIFO state, head scan, result registers.
// Depends on kwsm_pkg, kwsm_ram and the assertion macro header.
`include "k_way_sorted_merge_assert.svh"

module kwsm_dp import kwsm_pkg::*; #(
  parameter int unsigned LANES      = LANES_DEF,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kwsm_cmd_t                 cmd_i,
  output kwsm_stat_t                stat_o,
  input  logic                      cfg_valid_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic [LANE_W-1:0]         lane_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic                      has_value_i,
  input  logic                      lane_end_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic signed [VALUE_W-1:0] merged_value_o,
  output logic [LANE_W-1:0]         source_lane_o,
  output logic [1:0]                status_o,
  output logic                      merge_done_o,
  output logic                      run_last_o
);

  localparam int unsigned LW = $clog2(LANES);
  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW = $clog2(LANES * FIFO_DEPTH);
  localparam int unsigned UW = $clog2(LANES + 1);

  // configuration
  logic [CFG_W-1:0] lanes_used_q;
  logic [UW-1:0]    used;
  logic [LANES-1:0] used_mask;

  // latched input item
  logic [LANE_W-1:0]         in_lane_q;
  logic signed [VALUE_W-1:0] in_val_q;
  logic                      in_has_q;
  logic                      in_end_q;

  // lane state
  logic [CW-1:0]    count_q  [LANES];
  logic [PW-1:0]    rd_ptr_q [LANES];
  logic [PW-1:0]    wr_ptr_q [LANES];
  logic [LANES-1:0] nonempty_q;
  logic [LANES-1:0] closed_q;
  logic [LANES-1:0] cand;

  // scan
  logic [LW-1:0]             sel_q;
  logic [LW-1:0]             rd_lane_q;
  logic                      rd_vld_q;
  logic [LW-1:0]             best_lane_q;
  logic signed [VALUE_W-1:0] best_val_q;
  logic                      best_vld_q;
  logic                      take;
  logic [LW-1:0]             best_lane_nx;

  // memory
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  // per-item result bookkeeping
  logic [RESCNT_W-1:0]       res_cnt_q;
  logic                      emitted_q;
  logic                      pend_vld_q;
  logic signed [VALUE_W-1:0] pend_val_q;
  logic [LANE_W-1:0]         pend_lane_q;
  kwsm_status_e              pend_st_q;
  logic                      pend_done_q;

  // drop decision
  logic         bad_lane;
  logic         drop;
  kwsm_status_e drop_code;
  logic         push;

  // output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] out_val_q;
  logic [LANE_W-1:0]         out_lane_q;
  kwsm_status_e              out_st_q;
  logic                      out_done_q;
  logic                      out_last_q;
  logic                      out_free;
  logic                      out_load;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_used_q <= LANES_USED_RST;
    end else if (cfg_valid_i && cmd_i.idle) begin
      lanes_used_q <= cfg_data_i;
    end
  end

  // clamp the lane count to 1..LANES
  always_comb begin
    if (lanes_used_q == '0) begin
      used = UW'(1);
    end else if (CMP_W'(lanes_used_q) > CMP_W'(LANES)) begin
      used = UW'(LANES);
    end else begin
      used = UW'(lanes_used_q);
    end
    for (int i = 0; i < LANES; i++) begin
      used_mask[i] = (i < int'(used));
    end
  end

  assign cand = used_mask & nonempty_q;

  // ---------------------------------------------------------------- input
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      in_lane_q <= lane_i;
      in_val_q  <= value_i;
      in_has_q  <= has_value_i;
      in_end_q  <= lane_end_i;
    end
  end

  assign bad_lane = CMP_W'(in_lane_q) >= CMP_W'(used);

  always_comb begin
    drop      = 1'b0;
    drop_code = ST_CLOSED;
    if (bad_lane || closed_q[sel_q]) begin
      drop      = 1'b1;
      drop_code = ST_CLOSED;
    end else if (in_has_q && (count_q[sel_q] == CW'(FIFO_DEPTH))) begin
      drop      = 1'b1;
      drop_code = ST_FULL;
    end
  end

  assign push = cmd_i.check && !drop;

  // ---------------------------------------------------------------- lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        count_q[i]  <= '0;
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
      end
      nonempty_q <= '0;
      closed_q   <= '0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < LANES; i++) begin
        count_q[i]  <= '0;
        rd_ptr_q[i] <= '0;
        wr_ptr_q[i] <= '0;
      end
      nonempty_q <= '0;
      closed_q   <= '0;
    end else if (push) begin
      if (in_has_q) begin
        wr_ptr_q[sel_q]   <= (wr_ptr_q[sel_q] == PW'(FIFO_DEPTH - 1)) ? '0
                             : wr_ptr_q[sel_q] + 1'b1;
        count_q[sel_q]    <= count_q[sel_q] + 1'b1;
        nonempty_q[sel_q] <= 1'b1;
      end
      if (in_end_q) begin
        closed_q[sel_q] <= 1'b1;
      end
    end else if (cmd_i.pop) begin
      rd_ptr_q[sel_q]   <= (rd_ptr_q[sel_q] == PW'(FIFO_DEPTH - 1)) ? '0
                           : rd_ptr_q[sel_q] + 1'b1;
      count_q[sel_q]    <= count_q[sel_q] - 1'b1;
      nonempty_q[sel_q] <= (count_q[sel_q] != CW'(1));
    end
  end

  assign ram_we    = push && in_has_q;
  assign ram_waddr = AW'(AW'(sel_q) * AW'(FIFO_DEPTH) + AW'(wr_ptr_q[sel_q]));
  assign ram_raddr = AW'(AW'(sel_q) * AW'(FIFO_DEPTH) + AW'(rd_ptr_q[sel_q]));

  kwsm_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (LANES * FIFO_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_val_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------- scan
  // strict less-than keeps the lower lane on ties, lanes are visited in order
  assign take = rd_vld_q && (!best_vld_q || ($signed(ram_rdata) < best_val_q));
  assign best_lane_nx = take ? rd_lane_q : best_lane_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        sel_q <= LW'(lane_i);
      end else if (cmd_i.scan_start) begin
        sel_q <= '0;
      end else if (cmd_i.scan_step && !stat_o.scan_last) begin
        sel_q <= sel_q + 1'b1;
      end else if (cmd_i.scan_tail) begin
        sel_q <= best_lane_nx;
      end
      rd_vld_q <= cmd_i.scan_step && cand[sel_q];
      if (cmd_i.scan_start) begin
        best_vld_q <= 1'b0;
      end else if ((cmd_i.scan_step || cmd_i.scan_tail) && take) begin
        best_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lane_q <= sel_q;
    if ((cmd_i.scan_step || cmd_i.scan_tail) && take) begin
      best_val_q  <= $signed(ram_rdata);
      best_lane_q <= rd_lane_q;
    end
  end

  // ---------------------------------------------------------------- results
  // pend holds the newest result until we know whether it closes the item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      res_cnt_q  <= '0;
      emitted_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        pend_vld_q <= 1'b0;
        res_cnt_q  <= '0;
        emitted_q  <= 1'b0;
      end else if ((cmd_i.check && drop) || cmd_i.pop || cmd_i.mark) begin
        pend_vld_q <= 1'b1;
        res_cnt_q  <= res_cnt_q + 1'b1;
        if (cmd_i.pop) begin
          emitted_q <= 1'b1;
        end
      end else if (cmd_i.last) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check && drop) begin
      pend_val_q  <= '0;
      pend_lane_q <= in_lane_q;
      pend_st_q   <= drop_code;
      pend_done_q <= 1'b0;
    end else if (cmd_i.pop) begin
      pend_val_q  <= best_val_q;
      pend_lane_q <= LANE_W'(best_lane_q);
      pend_st_q   <= ST_DATA;
      pend_done_q <= 1'b0;
    end else if (cmd_i.mark) begin
      pend_val_q  <= '0;
      pend_lane_q <= in_lane_q;
      pend_st_q   <= ST_END;
      pend_done_q <= 1'b1;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ((cmd_i.pop || cmd_i.mark) && pend_vld_q) || cmd_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= pend_val_q;
      out_lane_q <= pend_lane_q;
      out_st_q   <= pend_st_q;
      out_done_q <= pend_done_q || (cmd_i.last && cmd_i.set_done);
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign merged_value_o = out_val_q;
  assign source_lane_o  = out_lane_q;
  assign status_o       = out_st_q;
  assign merge_done_o   = out_done_q;
  assign run_last_o     = out_last_q;

  // ---------------------------------------------------------------- status
  always_comb begin
    stat_o            = '0;
    stat_o.blocked    = |(used_mask & ~nonempty_q & ~closed_q);
    stat_o.any_cand   = |cand;
    stat_o.all_done   = ~|(used_mask & (~closed_q | nonempty_q));
    stat_o.cap_hit    = (res_cnt_q == RESCNT_W'(MAX_OUT));
    stat_o.scan_last  = (sel_q == LW'(LANES - 1));
    stat_o.pend_valid = pend_vld_q;
    stat_o.out_free   = out_free;
    stat_o.emitted    = emitted_q;
  end

  // ---------------------------------------------------------------- checks
  `KWSM_ASSERT(a_out_load_free, clk_i, rst_ni, out_load && out_valid_q, !out_stall_i)
  `KWSM_ASSERT(a_pop_has_best, clk_i, rst_ni, cmd_i.pop, best_vld_q)
  `KWSM_ASSERT_NEXT(a_tail_finds_head, clk_i, rst_ni, cmd_i.scan_tail, best_vld_q)
  `KWSM_ASSERT(a_done_is_last, clk_i, rst_ni, out_valid_q && out_done_q, out_last_q)

endmodule

FILE: test/k_way_sorted_merge_tb.sv
// Self-checking testbench for k_way_sorted_merge: predicts every result of every item and
// compares it field by field while both sides idle and stall at random.
// Depends on kwsm_pkg and the k_way_sorted_merge RTL only.
module k_way_sorted_merge_tb;
  import kwsm_pkg::*;

  localparam int LANES       = LANES_DEF;
  localparam int FIFO_DEPTH  = FIFO_DEPTH_DEF;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 48;
  localparam int SETTLE      = 4 * (LANES + 3) + 8;
  localparam int PRINT_CAP   = 100;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct {
    logic [LANE_W-1:0]         lane;
    logic signed [VALUE_W-1:0] value;
    logic                      has_value;
    logic                      lane_end;
    bit                        hold_for_drain;
  } lane_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [LANE_W-1:0]         lane;
    kwsm_status_e              status;
    logic                      merge_done;
    logic                      run_last;
  } merge_result_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [LANE_W-1:0]         lane_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      has_value_i;
  logic                      lane_end_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [VALUE_W-1:0] merged_value_o;
  logic [LANE_W-1:0]         source_lane_o;
  logic [1:0]                status_o;
  logic                      merge_done_o;
  logic                      run_last_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_W-1:0]          cfg_data_i;

  k_way_sorted_merge #(
    .LANES      (LANES),
    .FIFO_DEPTH (FIFO_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .lane_i         (lane_i),
    .value_i        (value_i),
    .has_value_i    (has_value_i),
    .lane_end_i     (lane_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .merged_value_o (merged_value_o),
    .source_lane_o  (source_lane_o),
    .status_o       (status_o),
    .merge_done_o   (merge_done_o),
    .run_last_o     (run_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // Predicted lane state
  logic signed [VALUE_W-1:0] lane_fifo [LANES][FIFO_DEPTH];
  logic [PTR_W:0]            fill_cnt [LANES];
  logic [PTR_W-1:0]          rd_ptr [LANES];
  logic [PTR_W-1:0]          wr_ptr [LANES];
  logic                      lane_shut [LANES];
  logic [CFG_W-1:0]          lanes_used_cfg;

  lane_item_t    items_pending [$];
  merge_result_t merge_expected [$];
  lane_item_t    cur_item;
  bit            presenting = 1'b0;
  int            burst_left = 1;
  int            gap_left = 0;
  int            stall_left = 0;
  int            free_left = 0;
  int            stall_level = 0;
  int            gap_level = 0;
  int            error_count = 0;
  int            queued_total = 0;
  int            cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) $display("mismatch @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic rearm_lanes();
    int i;
    for (i = 0; i < LANES; i++) begin
      fill_cnt[i] = '0;
      rd_ptr[i] = '0;
      wr_ptr[i] = '0;
      lane_shut[i] = 1'b0;
    end
  endtask

  function automatic int active_lanes();
    if (lanes_used_cfg == 0) return 1;
    if (lanes_used_cfg > LANES) return LANES;
    return int'(lanes_used_cfg);
  endfunction

  // Lowest head among taking-part lanes, or -1 while an open lane is empty or no lane holds data.
  function automatic int pick_head(input int used);
    int i, best;
    logic signed [VALUE_W-1:0] best_val, head;
    best = -1;
    best_val = '0;
    for (i = 0; i < used; i++) begin
      if (fill_cnt[i] == 0) begin
        if (!lane_shut[i]) return -1;
        continue;
      end
      head = lane_fifo[i][rd_ptr[i]];
      if (best < 0 || head < best_val) begin
        best = i;
        best_val = head;
      end
    end
    return best;
  endfunction

  function automatic merge_result_t make_result(input logic signed [VALUE_W-1:0] value,
                                                input logic [LANE_W-1:0] lane,
                                                input kwsm_status_e status);
    merge_result_t r;
    r.value = value;
    r.lane = lane;
    r.status = status;
    r.merge_done = 1'b0;
    r.run_last = 1'b0;
    return r;
  endfunction

  task automatic merge_step(input logic [LANE_W-1:0] lane,
                            input logic signed [VALUE_W-1:0] value,
                            input logic has_value, input logic lane_end);
    merge_result_t outs [MAX_OUT+1];
    int used, n, src, i;
    bit emitted, finished;
    used = active_lanes();
    n = 0;
    emitted = 1'b0;
    if (lane >= used || lane_shut[lane]) begin
      outs[n] = make_result('0, lane, ST_CLOSED);
      n++;
    end else if (has_value && fill_cnt[lane] >= FIFO_DEPTH) begin
      outs[n] = make_result('0, lane, ST_FULL);
      n++;
    end else begin
      if (has_value) begin
        lane_fifo[lane][wr_ptr[lane]] = value;
        wr_ptr[lane] = PTR_W'((wr_ptr[lane] + 1) % FIFO_DEPTH);
        fill_cnt[lane]++;
      end
      if (lane_end) lane_shut[lane] = 1'b1;
    end
    while (n < MAX_OUT) begin
      src = pick_head(used);
      if (src < 0) break;
      outs[n] = make_result(lane_fifo[src][rd_ptr[src]], LANE_W'(src), ST_DATA);
      n++;
      rd_ptr[src] = PTR_W'((rd_ptr[src] + 1) % FIFO_DEPTH);
      fill_cnt[src]--;
      emitted = 1'b1;
    end
    finished = 1'b1;
    for (i = 0; i < used; i++)
      if (!lane_shut[i] || fill_cnt[i] != 0) finished = 1'b0;
    if (finished) begin
      if (emitted) begin
        outs[n-1].merge_done = 1'b1;
      end else begin
        outs[n] = make_result('0, lane, ST_END);
        outs[n].merge_done = 1'b1;
        n++;
      end
      rearm_lanes();
    end
    if (n > 0) outs[n-1].run_last = 1'b1;
    for (i = 0; i < n; i++) merge_expected.push_back(outs[i]);
  endtask

  // Monitor: check results first, then predict from the item taken at this edge.
  always @(posedge clk_i) begin
    merge_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (merge_expected.size() == 0) begin
        report_error($sformatf("unexpected item: lane %0d status %0d value %0d",
                               source_lane_o, status_o, merged_value_o));
      end else begin
        want = merge_expected.pop_front();
        if (merged_value_o !== want.value)
          report_error($sformatf("merged_value %0d, want %0d (lane %0d)",
                                 merged_value_o, want.value, want.lane));
        if (source_lane_o !== want.lane)
          report_error($sformatf("source_lane %0d, want %0d", source_lane_o, want.lane));
        if (status_o !== want.status)
          report_error($sformatf("status %0d, want %0d (lane %0d)",
                                 status_o, want.status, want.lane));
        if (merge_done_o !== want.merge_done)
          report_error($sformatf("merge_done %0b, want %0b (lane %0d)",
                                 merge_done_o, want.merge_done, want.lane));
        if (run_last_o !== want.run_last)
          report_error($sformatf("run_last %0b, want %0b (lane %0d)",
                                 run_last_o, want.run_last, want.lane));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      merge_step(lane_i, value_i, has_value_i, lane_end_i);
      presenting = 1'b0;
    end
  end

  // Driver: bursts and gaps on the input side, its own stall pattern on the output side.
  always @(negedge clk_i) begin
    logic next_stall;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (!presenting && gap_left > 0) begin
        gap_left--;
      end else if (!presenting && items_pending.size() != 0 &&
                   (!items_pending[0].hold_for_drain || merge_expected.size() == 0)) begin
        cur_item = items_pending.pop_front();
        presenting = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = (gap_level == 0) ? 0 : $urandom_range(1, gap_level * 6);
        end
      end
      in_valid_i <= presenting;
      if (presenting) begin
        lane_i <= cur_item.lane;
        value_i <= cur_item.value;
        has_value_i <= cur_item.has_value;
        lane_end_i <= cur_item.lane_end;
      end else begin
        lane_i <= LANE_W'($urandom());
        value_i <= $urandom();
        has_value_i <= 1'($urandom());
        lane_end_i <= 1'($urandom());
      end

      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        next_stall = 1'b0;
      end else begin
        case (stall_level)
          0: begin
            free_left = 64;
          end
          1: begin
            stall_left = $urandom_range(0, 2);
            free_left = $urandom_range(1, 5);
          end
          default: begin
            stall_left = $urandom_range(2, 14);
            free_left = $urandom_range(0, 3);
          end
        endcase
        next_stall = 1'b0;
      end
      out_stall_i <= next_stall;
    end
  end

  function automatic lane_item_t item_of(input logic [LANE_W-1:0] lane,
                                         input logic signed [VALUE_W-1:0] value,
                                         input logic has_value, input logic lane_end);
    lane_item_t it;
    it.lane = lane;
    it.value = value;
    it.has_value = has_value;
    it.lane_end = lane_end;
    it.hold_for_drain = 1'b0;
    return it;
  endfunction

  task automatic queue_item(input lane_item_t it);
    items_pending.push_back(it);
    queued_total++;
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value(input bit narrow);
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      default: return narrow ? int'($urandom_range(0, 8)) - 4 : $urandom();
    endcase
  endfunction

  task automatic queue_noise(input int count);
    repeat (count)
      queue_item(item_of(LANE_W'($urandom_range(0, LANES - 1)), rand_value(1'b0),
                         1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0));
  endtask

  // One well-formed merge: ascending streams per lane, each closed by an end mark,
  // interleaved randomly, round robin, or lane by lane with lane 0 last.
  task automatic queue_merge(input int used);
    lane_item_t seq [LANES][FIFO_DEPTH+1];
    int cnt [LANES];
    int pos [LANES];
    logic signed [VALUE_W-1:0] vals [FIFO_DEPTH];
    logic signed [VALUE_W-1:0] tmp;
    int order, len, i, j, k, remaining, ln;
    bit narrow, hold;
    order = $urandom_range(0, 3);
    narrow = $urandom_range(0, 2) == 0;
    remaining = 0;
    for (i = 0; i < used; i++) begin
      len = $urandom_range(0, (order == 2) ? FIFO_DEPTH : 5);
      for (j = 0; j < len; j++) vals[j] = rand_value(narrow);
      for (j = 0; j < len; j++)
        for (k = 0; k + 1 < len - j; k++)
          if (vals[k] > vals[k+1]) begin
            tmp = vals[k];
            vals[k] = vals[k+1];
            vals[k+1] = tmp;
          end
      cnt[i] = 0;
      pos[i] = 0;
      for (j = 0; j < len; j++) begin
        seq[i][cnt[i]] = item_of(LANE_W'(i), vals[j], 1'b1, 1'b0);
        cnt[i]++;
      end
      if (len == 0 || $urandom_range(0, 1) == 1) begin
        seq[i][cnt[i]] = item_of(LANE_W'(i), $urandom(), 1'b0, 1'b1);
        cnt[i]++;
      end else begin
        seq[i][cnt[i]-1].lane_end = 1'b1;
      end
      remaining += cnt[i];
    end
    hold = $urandom_range(0, 7) == 0;
    ln = (order == 2) ? used - 1 : -1;
    while (remaining > 0) begin
      case (order)
        2: begin
          while (pos[ln] >= cnt[ln]) ln--;
        end
        3: begin
          ln = (ln + 1) % used;
          while (pos[ln] >= cnt[ln]) ln = (ln + 1) % used;
        end
        default: begin
          ln = $urandom_range(0, used - 1);
          while (pos[ln] >= cnt[ln]) ln = (ln + 1) % used;
        end
      endcase
      seq[ln][pos[ln]].hold_for_drain = hold;
      hold = 1'b0;
      queue_item(seq[ln][pos[ln]]);
      pos[ln]++;
      remaining--;
    end
  endtask

  task automatic wait_quiet();
    while (items_pending.size() != 0 || presenting || merge_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_lanes_used(input logic [CFG_W-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    lanes_used_cfg = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [PHASES];
    int i, p, phase_start;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    lane_i = '0;
    value_i = '0;
    has_value_i = 1'b0;
    lane_end_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rearm_lanes();
    lanes_used_cfg = LANES_USED_RST;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset lane count: close every lane with a bare end mark, last one ends the merge.
    for (i = LANES - 1; i >= 0; i--)
      queue_item(item_of(LANE_W'(i), $urandom(), 1'b0, 1'b1));
    wait_quiet();

    // Two lanes: extremes, a tie, unused lane, full FIFO, closed lane, bare end.
    set_lanes_used(4'd2);
    queue_item(item_of(3'd0, 32'sh8000_0000, 1'b1, 1'b0));
    queue_item(item_of(3'd0, 32'sd5, 1'b1, 1'b0));
    queue_item(item_of(3'd1, 32'sd5, 1'b1, 1'b0));
    queue_item(item_of(3'd5, 32'sd1, 1'b1, 1'b0));
    for (i = 6; i <= 13; i++) queue_item(item_of(3'd1, i, 1'b1, 1'b0));
    queue_item(item_of(3'd1, 32'sd14, 1'b1, 1'b1));
    queue_item(item_of(3'd0, 32'sh7fff_ffff, 1'b1, 1'b1));
    queue_item(item_of(3'd0, 32'sd3, 1'b1, 1'b0));
    queue_item(item_of(3'd1, $urandom(), 1'b0, 1'b1));

    phase_cfg = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5, 4'd2};
    phase_cfg[PHASES-1] = CFG_W'($urandom_range(0, 15));
    for (p = 0; p < PHASES; p++) begin
      wait_quiet();
      set_lanes_used(phase_cfg[p]);
      stall_level = p % 3;
      gap_level = (p == 0) ? 0 : (p + 1) % 3;
      phase_start = queued_total;
      while (queued_total - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) queue_noise($urandom_range(1, 3));
        else queue_merge(active_lanes());
      end
    end

    wait_quiet();
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
